### rtl/core/c2s_pkg.sv
package c2s_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SCALE_BITS   = 24;
  // z is scaled by the CORDIC gain in Q30, then brought back to the 2^24 scale
  localparam int GAIN_SHIFT   = 30 - SCALE_BITS;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

  localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;

  // round(atan(2^-i) * 2^31 / pi), a full turn being 2^32
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNINIT = 2'd1,
    ST_ZERO   = 2'd2
  } status_t;

endpackage

### rtl/core/cartesian_to_spherical.sv
// Path: front stages 1 and 2, azimuth chain, stage between the chains, polar chain, output
// register. Throughput: one item per cycle unless frozen; two chains of 30 CORDIC cells and
// a square-root chain of COMPONENT_WIDTH cells each take one step per cycle. The pipeline
// freezes only while out_valid and out_stall are high and the last cell is full.
// Reset (rst_n low, synchronous) clears all valid flags; data registers are not reset.
module cartesian_to_spherical #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_WIDTH     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x_component,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y_component,
  input  logic signed [COMPONENT_WIDTH-1:0] in_z_component,
  input  logic                              in_initialized,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [COMPONENT_WIDTH-1:0]        out_radius,
  output logic signed [ANGLE_WIDTH-1:0]     out_azimuth,
  output logic [ANGLE_WIDTH-1:0]            out_polar,
  output logic [1:0]                        out_status
);

  localparam int W     = COMPONENT_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  localparam int NS    = c2s_pkg::CORDIC_STEPS;
  localparam int CW    = W + c2s_pkg::SCALE_BITS + 5;
  localparam int RW    = 2 * W + 1;
  localparam int ASH   = 32 - AW;
  localparam int SW1   = CW + 3;
  localparam int SW2   = AW + 2;
  localparam int DLY   = 2 * NS + 1 - W;
  localparam logic [31:0] HALF = 32'(1) << (ASH - 1);

  logic en;
  logic accept;
  logic v_last;

  // front stage 1
  logic                   v1_r;
  logic signed [W-1:0]    s1_x_r, s1_y_r, s1_z_r;
  logic                   s1_init_r;
  logic signed [2*W-1:0]  s1_xx_r, s1_yy_r, s1_zz_r;
  logic signed [W+31:0]   s1_zg_r;

  // front stage 2
  logic                   v2_r;
  logic [2*W-1:0]         s2_s_r;
  logic signed [CW-1:0]   s2_x_r, s2_y_r;
  logic [31:0]            s2_acc_r;
  logic [SW1-1:0]         s2_side_r;
  logic signed [CW-1:0]   xs2, ys2, x2_nxt, y2_nxt;
  logic [31:0]            acc2_nxt;
  logic                   axis2;
  c2s_pkg::status_t       st2;

  // chain wiring
  logic                   c1_v    [NS+1];
  logic signed [CW-1:0]   c1_x    [NS+1];
  logic signed [CW-1:0]   c1_y    [NS+1];
  logic [31:0]            c1_acc  [NS+1];
  logic [SW1-1:0]         c1_side [NS+1];
  logic                   c2_v    [NS+1];
  logic signed [CW-1:0]   c2_x    [NS+1];
  logic signed [CW-1:0]   c2_y    [NS+1];
  logic [31:0]            c2_acc  [NS+1];
  logic [SW2-1:0]         c2_side [NS+1];
  logic [RW-1:0]          sq_rem  [W+1];
  logic [RW-1:0]          sq_root [W+1];

  // stage between the chains
  logic                   vp_r;
  logic signed [CW-1:0]   p_x_r, p_y_r;
  logic [31:0]            p_acc_r;
  logic [SW2-1:0]         p_side_r;
  logic signed [CW-1:0]   p_zs, p_mx, px_nxt, py_nxt;
  logic [31:0]            pacc_nxt, az_sum;
  logic [AW-1:0]          az_nxt;

  // radius alignment
  logic [W-1:0]           rad_round;
  logic [W-1:0]           rad_dly [DLY];

  // output
  logic [31:0]            pol, pol_sum;
  c2s_pkg::status_t       st_last;
  logic                   out_valid_r;
  logic [W-1:0]           out_radius_r;
  logic [AW-1:0]          out_azimuth_r;
  logic [AW-1:0]          out_polar_r;
  logic [1:0]             out_status_r;

  assign v_last   = c2_v[NS];
  assign en       = !(v_last && out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vp_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
      vp_r <= c1_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r    <= in_x_component;
      s1_y_r    <= in_y_component;
      s1_z_r    <= in_z_component;
      s1_init_r <= in_initialized;
      s1_xx_r   <= in_x_component * in_x_component;
      s1_yy_r   <= in_y_component * in_y_component;
      s1_zz_r   <= in_z_component * in_z_component;
      s1_zg_r   <= in_z_component * c2s_pkg::GAIN_Q30;
    end
  end

  // scale x, y and fold a left-half vector into the right half-plane
  always_comb begin
    xs2   = CW'(s1_x_r) <<< c2s_pkg::SCALE_BITS;
    ys2   = CW'(s1_y_r) <<< c2s_pkg::SCALE_BITS;
    axis2 = (s1_x_r == '0) && (s1_y_r == '0);
    if (!s1_init_r) begin
      st2 = c2s_pkg::ST_UNINIT;
    end else if (axis2 && (s1_z_r == '0)) begin
      st2 = c2s_pkg::ST_ZERO;
    end else begin
      st2 = c2s_pkg::ST_OK;
    end
    if (xs2[CW-1]) begin
      if (!ys2[CW-1]) begin
        x2_nxt   = ys2;
        y2_nxt   = -xs2;
        acc2_nxt = c2s_pkg::QUARTER_POS;
      end else begin
        x2_nxt   = -ys2;
        y2_nxt   = xs2;
        acc2_nxt = c2s_pkg::QUARTER_NEG;
      end
    end else begin
      x2_nxt   = xs2;
      y2_nxt   = ys2;
      acc2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_s_r    <= $unsigned(s1_xx_r) + $unsigned(s1_yy_r) + $unsigned(s1_zz_r);
      s2_x_r    <= x2_nxt;
      s2_y_r    <= y2_nxt;
      s2_acc_r  <= acc2_nxt;
      s2_side_r <= {CW'(s1_zg_r >>> c2s_pkg::GAIN_SHIFT), axis2, st2};
    end
  end

  // square root, one result bit per cell
  assign sq_rem[0]  = RW'(s2_s_r);
  assign sq_root[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    c2s_sqrt_cell #(
      .RW  (RW),
      .POS (W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1])
    );
  end

  // round half up
  assign rad_round = W'(sq_root[W] + RW'(sq_rem[W] > sq_root[W]));

  always_ff @(posedge clk) begin
    if (en) begin
      rad_dly[0] <= rad_round;
      for (int i = 1; i < DLY; i++) begin
        rad_dly[i] <= rad_dly[i-1];
      end
    end
  end

  // azimuth chain
  assign c1_v[0]    = v2_r;
  assign c1_x[0]    = s2_x_r;
  assign c1_y[0]    = s2_y_r;
  assign c1_acc[0]  = s2_acc_r;
  assign c1_side[0] = s2_side_r;

  for (genvar i = 0; i < NS; i++) begin : g_azi
    c2s_cordic_cell #(
      .CW   (CW),
      .STEP (i),
      .SW   (SW1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (c1_v[i]),
      .in_x      (c1_x[i]),
      .in_y      (c1_y[i]),
      .in_acc    (c1_acc[i]),
      .in_side   (c1_side[i]),
      .out_valid (c1_v[i+1]),
      .out_x     (c1_x[i+1]),
      .out_y     (c1_y[i+1]),
      .out_acc   (c1_acc[i+1]),
      .out_side  (c1_side[i+1])
    );
  end

  // polar vector is (K*z, K*rho); on the z axis rho and azimuth are zero
  always_comb begin
    p_zs   = c1_side[NS][SW1-1:3];
    p_mx   = c1_side[NS][2] ? '0 : c1_x[NS];
    az_sum = c1_acc[NS] + HALF;
    az_nxt = c1_side[NS][2] ? '0 : az_sum[31:ASH];
    if (p_zs[CW-1]) begin
      if (!p_mx[CW-1]) begin
        px_nxt   = p_mx;
        py_nxt   = -p_zs;
        pacc_nxt = c2s_pkg::QUARTER_POS;
      end else begin
        px_nxt   = -p_mx;
        py_nxt   = p_zs;
        pacc_nxt = c2s_pkg::QUARTER_NEG;
      end
    end else begin
      px_nxt   = p_zs;
      py_nxt   = p_mx;
      pacc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x_r    <= px_nxt;
      p_y_r    <= py_nxt;
      p_acc_r  <= pacc_nxt;
      p_side_r <= {az_nxt, c1_side[NS][1:0]};
    end
  end

  // polar chain
  assign c2_v[0]    = vp_r;
  assign c2_x[0]    = p_x_r;
  assign c2_y[0]    = p_y_r;
  assign c2_acc[0]  = p_acc_r;
  assign c2_side[0] = p_side_r;

  for (genvar i = 0; i < NS; i++) begin : g_pol
    c2s_cordic_cell #(
      .CW   (CW),
      .STEP (i),
      .SW   (SW2)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (c2_v[i]),
      .in_x      (c2_x[i]),
      .in_y      (c2_y[i]),
      .in_acc    (c2_acc[i]),
      .in_side   (c2_side[i]),
      .out_valid (c2_v[i+1]),
      .out_x     (c2_x[i+1]),
      .out_y     (c2_y[i+1]),
      .out_acc   (c2_acc[i+1]),
      .out_side  (c2_side[i+1])
    );
  end

  // a negative angle, including exactly half a turn, clamps to zero
  always_comb begin
    pol     = c2_acc[NS][31] ? '0 : c2_acc[NS];
    pol_sum = pol + HALF;
    st_last = c2s_pkg::status_t'(c2_side[NS][1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_status_r <= st_last;
      if (st_last == c2s_pkg::ST_OK) begin
        out_radius_r  <= rad_dly[DLY-1];
        out_azimuth_r <= c2_side[NS][SW2-1:2];
        out_polar_r   <= pol_sum[31:ASH];
      end else begin
        out_radius_r  <= '0;
        out_azimuth_r <= '0;
        out_polar_r   <= '0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_radius  = out_radius_r;
  assign out_azimuth = $signed(out_azimuth_r);
  assign out_polar   = out_polar_r;
  assign out_status  = out_status_r;

endmodule

### rtl/core/c2s_sqrt_cell.sv
module c2s_sqrt_cell #(
  parameter int RW  = 33,
  parameter int POS = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_root,
  output logic [RW-1:0] out_rem,
  output logic [RW-1:0] out_root
);

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * POS);

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] root_r;

  always_comb begin
    trial = in_root + BIT;
    if (in_rem >= trial) begin
      rem_nxt  = in_rem - trial;
      root_nxt = (in_root >> 1) + BIT;
    end else begin
      rem_nxt  = in_rem;
      root_nxt = in_root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_rem  = rem_r;
  assign out_root = root_r;

endmodule

### rtl/core/c2s_cordic_cell.sv
module c2s_cordic_cell #(
  parameter int CW   = 45,
  parameter int STEP = 0,
  parameter int SW   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic [31:0]          in_acc,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic [31:0]          out_acc,
  output logic [SW-1:0]        out_side
);

  localparam logic [31:0] ANGLE = c2s_pkg::ATAN_TAB[STEP];

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic [31:0]          acc_nxt;
  logic                 valid_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic [31:0]          acc_r;
  logic [SW-1:0]        side_r;

  always_comb begin
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
    // rotate toward y = 0
    if (!in_y[CW-1]) begin
      x_nxt   = in_x + ys;
      y_nxt   = in_y - xs;
      acc_nxt = in_acc + ANGLE;
    end else begin
      x_nxt   = in_x - ys;
      y_nxt   = in_y + xs;
      acc_nxt = in_acc - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      acc_r  <= acc_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_acc   = acc_r;
  assign out_side  = side_r;

endmodule
